// ===== hw/rtl/playfair_digraph_encrypt_defines.svh =====
// Assertion macros for the Playfair digraph encryptor.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_DEFINES_SVH

`ifndef SYNTHESIS
`define PFE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFE_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/pfe_pkg.sv =====
// Shared types, codes and helper functions for the Playfair digraph encryptor.
// No dependencies.
`timescale 1ns / 1ps

package pfe_pkg;

	localparam logic [1:0] REQ_CLEAR   = 2'd0;
	localparam logic [1:0] REQ_KEY     = 2'd1;
	localparam logic [1:0] REQ_ENCRYPT = 2'd2;

	localparam logic [4:0] LETTER_I  = 5'd8;
	localparam logic [4:0] LETTER_J  = 5'd9;
	localparam logic [4:0] LETTER_Z  = 5'd25;
	localparam logic [4:0] SQ_CELLS  = 5'd25;
	localparam logic [2:0] SQ_LAST   = 3'd4;

	typedef struct packed {
		logic [1:0] req_type;
		logic [4:0] letter_a;
		logic [4:0] letter_b;
	} in_item_t;

	typedef struct packed {
		logic [4:0] cipher_a;
		logic [4:0] cipher_b;
	} out_item_t;

	typedef struct packed {
		logic clear;
		logic key;
		logic latch;
		logic fill_step;
		logic rd_pos;
		logic map;
	} pfe_cmd_t;

	typedef struct packed {
		logic enc_ok;
		logic complete;
		logic fill_last;
	} pfe_sts_t;

	typedef struct packed {
		logic [2:0] row;
		logic [2:0] col;
	} pos_rc_t;

	function automatic logic [4:0] fold_j(input logic [4:0] l);
		return (l == LETTER_J) ? LETTER_I : l;
	endfunction

	function automatic pos_rc_t pos_split(input logic [4:0] p);
		logic [4:0] m;
		pos_rc_t rc;
		m = (p >= SQ_CELLS) ? (p - SQ_CELLS) : p;
		if (m >= 5'd20) begin
			rc.row = 3'd4;
			rc.col = 3'(m - 5'd20);
		end else if (m >= 5'd15) begin
			rc.row = 3'd3;
			rc.col = 3'(m - 5'd15);
		end else if (m >= 5'd10) begin
			rc.row = 3'd2;
			rc.col = 3'(m - 5'd10);
		end else if (m >= 5'd5) begin
			rc.row = 3'd1;
			rc.col = 3'(m - 5'd5);
		end else begin
			rc.row = 3'd0;
			rc.col = 3'(m);
		end
		return rc;
	endfunction

	function automatic logic [4:0] pos_join(input pos_rc_t rc);
		return (5'(rc.row) << 2) + 5'(rc.row) + 5'(rc.col);
	endfunction

	function automatic logic [2:0] inc_mod5(input logic [2:0] x);
		return (x == SQ_LAST) ? 3'd0 : (x + 3'd1);
	endfunction

endpackage

// ===== hw/rtl/pfe_ctrl.sv =====
// Controller state machine for the Playfair digraph encryptor.
// Depends on pfe_pkg for request codes and the command/status structs.
`timescale 1ns / 1ps

module pfe_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      req_type,
	input  pfe_pkg::pfe_sts_t sts,
	output pfe_pkg::pfe_cmd_t cmd,
	output logic            busy
);
	import pfe_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FILL  = 4'b0010,
		ST_RDPOS = 4'b0100,
		ST_MAP   = 4'b1000
	} state_t;

	state_t st_q;
	state_t st_nxt;

	always_comb begin
		cmd    = '0;
		st_nxt = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (start) begin
					unique case (req_type)
						REQ_CLEAR: cmd.clear = 1'b1;
						REQ_KEY:   cmd.key = 1'b1;
						REQ_ENCRYPT: begin
							if (sts.enc_ok) begin
								cmd.latch = 1'b1;
								st_nxt = sts.complete ? ST_MAP : ST_FILL;
							end
						end
						default: ;
					endcase
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					st_nxt = ST_RDPOS;
				end
			end
			ST_RDPOS: begin
				cmd.rd_pos = 1'b1;
				st_nxt = ST_MAP;
			end
			ST_MAP: begin
				cmd.map = 1'b1;
				st_nxt = ST_IDLE;
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	assign busy = (st_q != ST_IDLE);

endmodule

// ===== hw/rtl/pfe_dp.sv =====
// Datapath for the Playfair digraph encryptor: key square memories, fill walk, lookup.
// Depends on pfe_pkg and on the assertion macros header.
`timescale 1ns / 1ps
`include "playfair_digraph_encrypt_defines.svh"

module pfe_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  pfe_pkg::in_item_t request,
	input  pfe_pkg::pfe_cmd_t cmd,
	output pfe_pkg::pfe_sts_t sts,
	output logic              done,
	output pfe_pkg::out_item_t result
);
	import pfe_pkg::*;

	logic [4:0]  pos_mem [26];
	logic [4:0]  let_mem [25];

	logic [25:0] placed_q;
	logic [4:0]  fill_q;
	logic        complete_q;
	logic [4:0]  ch_q;
	logic [4:0]  a_q;
	logic [4:0]  b_q;
	logic [4:0]  pa_q;
	logic [4:0]  pb_q;
	logic [4:0]  ca_q;
	logic [4:0]  cb_q;
	logic        done_q;

	logic [4:0]  in_a_f;
	logic [4:0]  in_b_f;
	logic [4:0]  place_l;
	logic        place_try;
	logic        place_en;
	pos_rc_t     rc_a;
	pos_rc_t     rc_b;
	pos_rc_t     nrc_a;
	pos_rc_t     nrc_b;
	logic [4:0]  na;
	logic [4:0]  nb;

	assign in_a_f = fold_j(request.letter_a);
	assign in_b_f = fold_j(request.letter_b);

	always_comb begin
		if (cmd.fill_step) begin
			place_l   = ch_q;
			place_try = (ch_q != LETTER_J);
		end else begin
			place_l   = in_a_f;
			place_try = cmd.key && (request.letter_a <= LETTER_Z);
		end
		place_en = place_try && !placed_q[place_l] && (fill_q < SQ_CELLS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			placed_q   <= '0;
			fill_q     <= '0;
			complete_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.map;
			if (cmd.clear) begin
				placed_q   <= '0;
				fill_q     <= '0;
				complete_q <= 1'b0;
			end else begin
				if (place_en) begin
					placed_q[place_l] <= 1'b1;
					fill_q <= fill_q + 5'd1;
				end
				if (cmd.fill_step && sts.fill_last) begin
					complete_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (place_en) begin
			pos_mem[place_l] <= fill_q;
			let_mem[fill_q]  <= place_l;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			a_q  <= in_a_f;
			b_q  <= in_b_f;
			ch_q <= '0;
			pa_q <= pos_mem[in_a_f];
			pb_q <= pos_mem[in_b_f];
		end else begin
			if (cmd.fill_step) begin
				ch_q <= ch_q + 5'd1;
			end
			if (cmd.rd_pos) begin
				pa_q <= pos_mem[a_q];
				pb_q <= pos_mem[b_q];
			end
		end
	end

	always_comb begin
		rc_a  = pos_split(pa_q);
		rc_b  = pos_split(pb_q);
		nrc_a = rc_a;
		nrc_b = rc_b;
		if (rc_a.row == rc_b.row) begin
			nrc_a.col = inc_mod5(rc_a.col);
			nrc_b.col = inc_mod5(rc_b.col);
		end else if (rc_a.col == rc_b.col) begin
			nrc_a.row = inc_mod5(rc_a.row);
			nrc_b.row = inc_mod5(rc_b.row);
		end else begin
			nrc_a.col = rc_b.col;
			nrc_b.col = rc_a.col;
		end
		na = pos_join(nrc_a);
		nb = pos_join(nrc_b);
	end

	always_ff @(posedge clk) begin
		if (cmd.map) begin
			ca_q <= let_mem[na];
			cb_q <= let_mem[nb];
		end
	end

	assign sts.enc_ok    = (request.letter_a <= LETTER_Z) && (request.letter_b <= LETTER_Z);
	assign sts.complete  = complete_q;
	assign sts.fill_last = (ch_q == LETTER_Z);

	assign done            = done_q;
	assign result.cipher_a = ca_q;
	assign result.cipher_b = cb_q;

	`PFE_ASSERT(a_done_after_map, clk, arst_n, done_q |-> $past(cmd.map), "result without lookup")
	`PFE_ASSERT(a_map_gives_done, clk, arst_n, cmd.map |=> done_q, "lookup without result")
	`PFE_ASSERT(a_map_needs_square, clk, arst_n, cmd.map |-> complete_q, "lookup on partial square")
	`PFE_ASSERT(a_fill_once, clk, arst_n, cmd.fill_step |-> !complete_q, "fill on complete square")
	`PFE_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !done_q, "result strobe in reset")

endmodule

// ===== hw/rtl/playfair_digraph_encrypt.sv =====
// Encrypt request: accept goes to the map state (via fill on an incomplete square); done is registered from map.
// First encrypt after clear/key load first walks the 26 letters once, then rereads both positions.
// Clear and key-letter requests complete at the accepting edge; busy stays low.
// Busy while an encrypt is in flight; the lookup registers the position reads, then the letter reads.
// Reset (arst_n low, asynchronous) empties the square; results cannot be stalled.
// Top level: joins controller and datapath.
`timescale 1ns / 1ps

module playfair_digraph_encrypt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  pfe_pkg::in_item_t  request,
	output logic               done,
	output pfe_pkg::out_item_t result
);
	import pfe_pkg::*;

	pfe_cmd_t cmd;
	pfe_sts_t sts;

	pfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (request.req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	pfe_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.done    (done),
		.result  (result)
	);

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for playfair_digraph_encrypt: directed table, then random key/encrypt runs.
// Checks typed rows against table values, others against a Playfair predictor; uses pfe_pkg and RTL.
`timescale 1ns / 1ps

module tb;
	import pfe_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [4:0] LT_A = 5'd0, LT_B = 5'd1, LT_C = 5'd2, LT_D = 5'd3, LT_E = 5'd4;
	localparam logic [4:0] LT_F = 5'd5, LT_G = 5'd6, LT_K = 5'd10, LT_L = 5'd11, LT_P = 5'd15;
	localparam logic [4:0] LT_V = 5'd21, LT_X = 5'd23, LT_Y = 5'd24;
	localparam logic [4:0] LT_OOR = 5'd26, LT_MAX = 5'd31;
	localparam int RAND_ITEMS = 1600;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} stim_row_t;

	typedef struct {
		bit        typed;
		out_item_t want;
	} typed_ent_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  request;
	logic      done;
	out_item_t result;

	out_item_t  cipher_q[$];
	typed_ent_t typed_q[$];
	stim_row_t  dir_tab[$];
	int         errors;
	bit         gaps_on;

	// predictor square state
	logic [25:0] sq_placed;
	logic [4:0]  sq_pos_of [26];
	logic [4:0]  sq_letter_at [25];
	int          sq_fill;
	bit          sq_complete;

	playfair_digraph_encrypt u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic void square_place(input logic [4:0] l);
		if (sq_placed[l] || sq_fill >= 25)
			return;
		sq_letter_at[sq_fill] = l;
		sq_pos_of[l] = 5'(sq_fill);
		sq_placed[l] = 1'b1;
		sq_fill++;
	endfunction

	function automatic bit playfair_predict(input in_item_t it, output out_item_t res);
		logic [4:0] a, b;
		int pa, pb, r1, c1, r2, c2, t;
		res = '0;
		case (it.req_type)
			REQ_CLEAR: begin
				sq_placed = '0;
				sq_fill = 0;
				sq_complete = 1'b0;
				return 1'b0;
			end
			REQ_KEY: begin
				if (it.letter_a <= LETTER_Z)
					square_place((it.letter_a == LETTER_J) ? LETTER_I : it.letter_a);
				return 1'b0;
			end
			REQ_ENCRYPT: begin
				if (it.letter_a > LETTER_Z || it.letter_b > LETTER_Z)
					return 1'b0;
				if (!sq_complete) begin
					for (int ch = 0; ch <= 25; ch++)
						if (5'(ch) != LETTER_J)
							square_place(5'(ch));
					sq_complete = 1'b1;
				end
				a = (it.letter_a == LETTER_J) ? LETTER_I : it.letter_a;
				b = (it.letter_b == LETTER_J) ? LETTER_I : it.letter_b;
				pa = sq_pos_of[a];
				pb = sq_pos_of[b];
				r1 = pa / 5; c1 = pa % 5;
				r2 = pb / 5; c2 = pb % 5;
				if (r1 == r2) begin
					c1 = (c1 + 1) % 5;
					c2 = (c2 + 1) % 5;
				end else if (c1 == c2) begin
					r1 = (r1 + 1) % 5;
					r2 = (r2 + 1) % 5;
				end else begin
					t = c1; c1 = c2; c2 = t;
				end
				res.cipher_a = sq_letter_at[r1 * 5 + c1];
				res.cipher_b = sq_letter_at[r2 * 5 + c2];
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// check results, then log accepted items
	always @(posedge clk) begin
		out_item_t  want, got;
		typed_ent_t te;
		if (arst_n) begin
			if (done) begin
				if (cipher_q.size() == 0) begin
					$error("unexpected result a=%0d b=%0d", result.cipher_a, result.cipher_b);
					errors++;
				end else begin
					want = cipher_q.pop_front();
					if (result.cipher_a !== want.cipher_a) begin
						$error("cipher_a expected %0d actual %0d", want.cipher_a, result.cipher_a);
						errors++;
					end
					if (result.cipher_b !== want.cipher_b) begin
						$error("cipher_b expected %0d actual %0d", want.cipher_b, result.cipher_b);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				te = typed_q.pop_front();
				if (playfair_predict(request, got))
					cipher_q.push_back(te.typed ? te.want : got);
			end
		end
	end

	function automatic stim_row_t dir_row(input logic [1:0] r, input logic [4:0] a,
			input logic [4:0] b = 5'd0, input bit t = 1'b0,
			input logic [4:0] ea = 5'd0, input logic [4:0] eb = 5'd0);
		stim_row_t s;
		s.item.req_type = r;
		s.item.letter_a = a;
		s.item.letter_b = b;
		s.typed = t;
		s.want.cipher_a = ea;
		s.want.cipher_b = eb;
		return s;
	endfunction

	task automatic send_item(input in_item_t it, input bit t = 1'b0, input out_item_t w = '0);
		typed_ent_t te;
		if (gaps_on && $urandom_range(99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		te.typed = t;
		te.want = w;
		typed_q.push_back(te);
		request <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (cipher_q.size() != 0);
	endtask

	function automatic in_item_t make_item(input logic [1:0] r, input logic [4:0] a,
			input logic [4:0] b);
		in_item_t it;
		it.req_type = r;
		it.letter_a = a;
		it.letter_b = b;
		return it;
	endfunction

	initial begin
		int sent, nkeys, nenc;
		bit paused;
		logic [4:0] la, lb;
		errors = 0;
		sent = 0;
		paused = 1'b0;
		gaps_on = 1'b1;
		sq_placed = '0;
		sq_fill = 0;
		sq_complete = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		dir_tab = '{
			dir_row(REQ_ENCRYPT, LT_A, LT_B, 1, LT_B, LT_C),
			dir_row(REQ_ENCRYPT, LT_A, LT_F, 1, LT_F, LT_L),
			dir_row(REQ_ENCRYPT, LT_A, LT_G, 1, LT_B, LT_F),
			dir_row(REQ_ENCRYPT, LETTER_Z, LETTER_Z, 1, LT_V, LT_V),
			dir_row(REQ_ENCRYPT, LETTER_J, LETTER_J, 1, LT_K, LT_K),
			dir_row(REQ_ENCRYPT, LT_Y, LT_E, 1, LETTER_Z, LT_D),
			dir_row(REQ_ENCRYPT, LT_E, LETTER_Z, 1, LT_K, LT_E),
			dir_row(REQ_KEY, LT_A),
			dir_row(REQ_ENCRYPT, LT_MAX, LT_A),
			dir_row(REQ_ENCRYPT, LT_A, LT_OOR),
			dir_row(REQ_UNUSED, LT_MAX, LT_MAX),
			dir_row(REQ_CLEAR, LT_A),
			dir_row(REQ_ENCRYPT, LT_B, LT_C, 1, LT_C, LT_D),
			dir_row(REQ_CLEAR, LT_A),
			dir_row(REQ_KEY, LT_MAX),
			dir_row(REQ_KEY, LETTER_J),
			dir_row(REQ_KEY, LETTER_I),
			dir_row(REQ_KEY, LETTER_Z),
			dir_row(REQ_KEY, LT_P),
			dir_row(REQ_KEY, LT_X),
			dir_row(REQ_ENCRYPT, LETTER_J, LETTER_Z),
			dir_row(REQ_ENCRYPT, LT_A, LT_A),
			dir_row(REQ_ENCRYPT, LT_X, LT_Y),
			dir_row(REQ_KEY, LT_B),
			dir_row(REQ_ENCRYPT, LT_B, LT_P)
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

		while (sent < RAND_ITEMS) begin
			gaps_on = !(sent >= 500 && sent < 900);
			if (!paused && sent >= 1000) begin
				paused = 1'b1;
				drain_results();
			end
			if ($urandom_range(99) < 80) begin
				send_item(make_item(REQ_CLEAR, 5'($urandom_range(31)), 5'($urandom_range(31))));
				nkeys = ($urandom_range(3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 8);
				for (int k = 0; k < nkeys; k++)
					send_item(make_item(REQ_KEY, 5'($urandom_range(25)),
						5'($urandom_range(31))));
				nenc = $urandom_range(1, 8);
				for (int k = 0; k < nenc; k++) begin
					la = 5'($urandom_range(25));
					lb = ($urandom_range(9) == 0) ? la : 5'($urandom_range(25));
					send_item(make_item(REQ_ENCRYPT, la, lb));
				end
				sent += 1 + nkeys + nenc;
			end else begin
				send_item(make_item(2'($urandom_range(3)), 5'($urandom_range(31)),
					5'($urandom_range(31))));
				sent += 1;
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
